// ===== design/wlex_pkg.sv =====
// ----------------------------------------------------------------------------
// Word lexer package
// Shared types, codes and character constants for the word lexer with escape
// processing and number classification.
// ----------------------------------------------------------------------------
package wlex_pkg;

    localparam int MAX_RESULTS = 4;

    typedef enum logic [2:0] {
        KIND_BYTE   = 3'd0,
        KIND_WORD   = 3'd1,
        KIND_NUMBER = 3'd2,
        KIND_ERROR  = 3'd3,
        KIND_LINE   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        LX_BETWEEN   = 3'd0,
        LX_WORD      = 3'd1,
        LX_ESC       = 3'd2,
        LX_ESC_ZERO  = 3'd3,
        LX_ESC_DIGIT = 3'd4,
        LX_DISCARD   = 3'd5
    } lex_phase_t;

    typedef enum logic [2:0] {
        NP_START = 3'd0,
        NP_ZERO  = 3'd1,
        NP_HEX   = 3'd2,
        NP_OCT   = 3'd3,
        NP_DEC   = 3'd4,
        NP_NOT   = 3'd5
    } num_phase_t;

    typedef enum logic [1:0] {
        Q_PLAIN  = 2'd0,
        Q_OPEN   = 2'd1,
        Q_CLOSED = 2'd2
    } quote_t;

    typedef enum logic [1:0] {
        SG_NONE  = 2'd0,
        SG_PLUS  = 2'd1,
        SG_MINUS = 2'd2
    } sign_t;

    typedef struct packed {
        lex_phase_t phase;
        quote_t     quote;
        logic [2:0] held;
        logic       close_seen;
        sign_t      sign;
        num_phase_t nphase;
        logic [31:0] acc;
    } lex_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [31:0] number;
    } result_t;

    localparam lex_state_t LEX_RESET = '{
        phase:      LX_BETWEEN,
        quote:      Q_PLAIN,
        held:       3'd0,
        close_seen: 1'b0,
        sign:       SG_NONE,
        nphase:     NP_START,
        acc:        32'd0
    };

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BKSP   = 8'h08;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

endpackage

// ===== design/wlex_step.sv =====
// ----------------------------------------------------------------------------
// Word lexer step
// Combinational update of the lexer state for one raw byte, giving the new
// state and up to four results in order.
// ----------------------------------------------------------------------------
module wlex_step
    import wlex_pkg::*;
(
    input  logic [7:0]                  ch,
    input  lex_state_t                  state,
    output lex_state_t                  state_next,
    output result_t [MAX_RESULTS-1:0]   results,
    output logic [2:0]                  count
);

    typedef struct packed {
        lex_state_t                st;
        result_t [MAX_RESULTS-1:0] res;
        logic [2:0]                cnt;
    } step_t;

    function automatic logic f_is_space(logic [7:0] c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    function automatic logic f_is_digit(logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic step_t f_emit(step_t s, kind_t k, logic [7:0] b, logic [31:0] n);
        step_t r;
        r = s;
        if (r.cnt < 3'(MAX_RESULTS))
        begin
            r.res[r.cnt[1:0]] = '{kind: k, data: b, number: n};
            r.cnt = r.cnt + 3'd1;
        end
        return r;
    endfunction

    function automatic lex_state_t f_classify(lex_state_t st, logic [7:0] b);
        lex_state_t  r;
        logic [31:0] dig;
        r   = st;
        dig = 32'(b - CH_ZERO);
        case (st.nphase)
            NP_START:
            begin
                if (b == CH_PLUS && st.sign == SG_NONE)
                    r.sign = SG_PLUS;
                else if (b == CH_MINUS && st.sign == SG_NONE)
                    r.sign = SG_MINUS;
                else if (b == CH_ZERO)
                begin
                    r.nphase = NP_ZERO;
                    r.acc    = 32'd0;
                end
                else if (f_is_digit(b))
                begin
                    r.nphase = NP_DEC;
                    r.acc    = dig;
                end
                else
                    r.nphase = NP_NOT;
            end
            NP_ZERO:
            begin
                if (b == CH_LX)
                begin
                    r.nphase = NP_HEX;
                    r.acc    = 32'd0;
                end
                else if (f_is_digit(b))
                begin
                    r.nphase = NP_OCT;
                    r.acc    = (st.acc << 3) + dig;
                end
                else
                    r.nphase = NP_NOT;
            end
            NP_HEX:
            begin
                if (b inside {[CH_UA:CH_UZ]})
                    r.acc = (st.acc << 4) + 32'(b - CH_UA + HEX_LETTER_BASE);
                else if (b inside {[CH_LA:CH_LZ]})
                    r.acc = (st.acc << 4) + 32'(b - CH_LA + HEX_LETTER_BASE);
                else if (f_is_digit(b))
                    r.acc = (st.acc << 4) + dig;
                else
                    r.nphase = NP_NOT;
            end
            NP_OCT:
            begin
                if (f_is_digit(b))
                    r.acc = (st.acc << 3) + dig;
                else
                    r.nphase = NP_NOT;
            end
            NP_DEC:
            begin
                if (f_is_digit(b))
                    r.acc = (st.acc << 3) + (st.acc << 1) + dig;
                else
                    r.nphase = NP_NOT;
            end
            default:
                r.nphase = NP_NOT;
        endcase
        return r;
    endfunction

    function automatic lex_state_t f_clear(lex_state_t st);
        lex_state_t r;
        r            = st;
        r.quote      = Q_PLAIN;
        r.held       = 3'd0;
        r.close_seen = 1'b0;
        r.sign       = SG_NONE;
        r.nphase     = NP_START;
        r.acc        = 32'd0;
        return r;
    endfunction

    function automatic step_t f_word_byte(step_t s, logic [7:0] b, logic rc);
        step_t r;
        r               = f_emit(s, KIND_BYTE, b, 32'd0);
        r.st            = f_classify(r.st, b);
        r.st.close_seen = rc;
        return r;
    endfunction

    function automatic logic f_paren_err(lex_state_t st);
        return (st.quote == Q_OPEN) || (st.quote == Q_CLOSED && !st.close_seen);
    endfunction

    function automatic step_t f_end_word(step_t s);
        step_t       r;
        logic [31:0] val;
        r   = s;
        val = (s.st.sign == SG_MINUS) ? (32'd0 - s.st.acc) : s.st.acc;
        if (f_paren_err(s.st))
            r = f_emit(r, KIND_ERROR, 8'd0, 32'd0);
        else if (s.st.nphase inside {NP_ZERO, NP_HEX, NP_OCT, NP_DEC})
            r = f_emit(r, KIND_NUMBER, 8'd0, val);
        else
            r = f_emit(r, KIND_WORD, 8'd0, 32'd0);
        r.st = f_clear(r.st);
        return r;
    endfunction

    function automatic step_t f_raw_in_word(step_t s, logic [7:0] c);
        step_t r;
        logic  err;
        r   = s;
        err = f_paren_err(s.st);
        if (c == CH_NUL)
        begin
            r          = f_end_word(r);
            r          = f_emit(r, KIND_LINE, 8'd0, 32'd0);
            r.st.phase = LX_BETWEEN;
        end
        else if (f_is_space(c) && s.st.quote != Q_OPEN)
        begin
            r          = f_end_word(r);
            r.st.phase = err ? LX_DISCARD : LX_BETWEEN;
        end
        else if (c == CH_CLOSE)
        begin
            r.st.quote = Q_CLOSED;
            r          = f_word_byte(r, c, 1'b1);
        end
        else if (c == CH_BSLASH)
        begin
            r.st.close_seen = 1'b0;
            r.st.phase      = LX_ESC;
        end
        else
            r = f_word_byte(r, c, 1'b0);
        return r;
    endfunction

    step_t s;

    always_comb
    begin
        s.st  = state;
        s.res = '0;
        s.cnt = 3'd0;
        case (state.phase)
            LX_BETWEEN:
            begin
                if (ch == CH_NUL)
                    s = f_emit(s, KIND_LINE, 8'd0, 32'd0);
                else if (!f_is_space(ch))
                begin
                    s.st       = f_clear(s.st);
                    s.st.quote = (ch == CH_OPEN) ? Q_OPEN : Q_PLAIN;
                    s.st.phase = LX_WORD;
                    s          = f_raw_in_word(s, ch);
                end
            end
            LX_WORD:
                s = f_raw_in_word(s, ch);
            LX_ESC:
            begin
                s.st.phase = LX_WORD;
                if (ch == CH_LN)
                    s = f_word_byte(s, CH_NL, 1'b0);
                else if (ch == CH_LB)
                    s = f_word_byte(s, CH_BKSP, 1'b0);
                else if (ch == CH_LT)
                    s = f_word_byte(s, CH_TAB, 1'b0);
                else if (ch == CH_ZERO)
                begin
                    s.st.close_seen = 1'b0;
                    s.st.phase      = LX_ESC_ZERO;
                end
                else if (ch == CH_NUL)
                begin
                    s = f_word_byte(s, CH_BSLASH, 1'b0);
                    s = f_raw_in_word(s, CH_NUL);
                end
                else
                    s = f_word_byte(s, ch, ch == CH_CLOSE);
            end
            LX_ESC_ZERO:
            begin
                if (ch inside {[CH_ZERO:CH_SEVEN]})
                begin
                    s.st.held  = ch[2:0];
                    s.st.phase = LX_ESC_DIGIT;
                end
                else
                begin
                    s.st.phase = LX_WORD;
                    s          = f_word_byte(s, CH_ZERO, 1'b0);
                    s          = f_raw_in_word(s, ch);
                end
            end
            LX_ESC_DIGIT:
            begin
                s.st.phase = LX_WORD;
                if (ch inside {[CH_ZERO:CH_SEVEN]})
                    s = f_word_byte(s, {2'b00, state.held, ch[2:0]}, 1'b0);
                else
                begin
                    s = f_word_byte(s, CH_ZERO, 1'b0);
                    s = f_word_byte(s, {CH_ZERO[7:3], state.held}, 1'b0);
                    s = f_raw_in_word(s, ch);
                end
                s.st.held = 3'd0;
            end
            default:
            begin
                if (ch == CH_NUL)
                begin
                    s          = f_emit(s, KIND_LINE, 8'd0, 32'd0);
                    s.st       = f_clear(s.st);
                    s.st.phase = LX_BETWEEN;
                end
            end
        endcase
    end

    assign state_next = s.st;
    assign results    = s.res;
    assign count      = s.cnt;

endmodule

// ===== design/word_lexer_with_escapes_and_numbers_core.sv =====
// ----------------------------------------------------------------------------
// Word lexer core
// Splits a byte stream into words with escape processing, classifies each
// word as a plain word or a signed number and reports line ends and errors.
// ----------------------------------------------------------------------------
// A byte taken into the input register passes through the step logic into the
// output register once that is free, which then presents its results in order.
// While res_stall is low, one byte is taken per cycle if each byte causes at
// most one result; else the output, one result per cycle, sets the rate.
// Reset clears the lexer state to between words and empties both registers.
module word_lexer_with_escapes_and_numbers_core
    import wlex_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         ch,
    input  logic               ch_valid,
    output logic               ch_stall,
    output logic [2:0]         kind,
    output logic [7:0]         out_byte,
    output logic signed [31:0] number,
    output logic               last,
    output logic               res_valid,
    input  logic               res_stall
);

    logic [7:0]                ch_reg;
    logic                      ch_full_reg;
    lex_state_t                state_reg;
    lex_state_t                state_next;
    result_t [MAX_RESULTS-1:0] bundle_reg;
    result_t [MAX_RESULTS-1:0] bundle_next;
    logic [2:0]                cnt_reg;
    logic [2:0]                cnt_next;
    logic [1:0]                idx_reg;
    logic [2:0]                cnt_m1;
    logic                      take;
    logic                      at_last;
    logic                      free;
    logic                      fire;
    logic                      accept;

    wlex_step u_step (
        .ch         (ch_reg),
        .state      (state_reg),
        .state_next (state_next),
        .results    (bundle_next),
        .count      (cnt_next)
    );

    assign cnt_m1    = cnt_reg - 3'd1;
    assign res_valid = (cnt_reg != 3'd0);
    assign at_last   = (idx_reg == cnt_m1[1:0]);
    assign take      = res_valid && !res_stall;
    assign free      = !res_valid || (take && at_last);
    assign fire      = ch_full_reg && free;
    assign ch_stall  = ch_full_reg && !fire;
    assign accept    = ch_valid && !ch_stall;

    assign kind     = bundle_reg[idx_reg].kind;
    assign out_byte = bundle_reg[idx_reg].data;
    assign number   = $signed(bundle_reg[idx_reg].number);
    assign last     = res_valid && at_last;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg <= ch;
        end
        if (fire)
        begin
            bundle_reg <= bundle_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_full_reg <= 1'b0;
            state_reg   <= LEX_RESET;
            cnt_reg     <= 3'd0;
            idx_reg     <= 2'd0;
        end
        else
        begin
            if (accept)
                ch_full_reg <= 1'b1;
            else if (fire)
                ch_full_reg <= 1'b0;

            if (fire)
            begin
                state_reg <= state_next;
                cnt_reg   <= cnt_next;
                idx_reg   <= 2'd0;
            end
            else if (take)
            begin
                if (at_last)
                begin
                    cnt_reg <= 3'd0;
                    idx_reg <= 2'd0;
                end
                else
                    idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

// ===== design/wlex_checker.sv =====
// ----------------------------------------------------------------------------
// Word lexer checker
// Port-level checks on the results of the word lexer core.
// ----------------------------------------------------------------------------
module wlex_checker
    import wlex_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic [7:0]         ch,
    input logic               ch_valid,
    input logic               ch_stall,
    input logic [2:0]         kind,
    input logic [7:0]         out_byte,
    input logic signed [31:0] number,
    input logic               last,
    input logic               res_valid,
    input logic               res_stall
);

    // A stalled result keeps its contents.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(kind) && $stable(out_byte)
            && $stable(number) && $stable(last))
        else $error("result changed while stalled");

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid && ch_stall |=> ch_valid && $stable(ch))
        else $error("input request changed while stalled");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != KIND_BYTE |-> out_byte == 8'd0)
        else $error("byte field set on a non-byte result");

    a_number_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != KIND_NUMBER |-> number == 32'sd0)
        else $error("number field set on a non-number result");

    a_line_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_LINE |-> last)
        else $error("line end not the last result of its byte");

endmodule

bind word_lexer_with_escapes_and_numbers_core wlex_checker u_wlex_checker (.*);

// ===== verif/tb_word_lexer_with_escapes_and_numbers_core.sv =====
// ----------------------------------------------------------------------------
// Word lexer core testbench
// Feeds a short directed table and then randomly built text lines through the
// lexer, one byte per request, with random idle cycles on both sides. Results
// are checked in order against the bench's behavioural lexer or typed table rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_word_lexer_with_escapes_and_numbers_core;
    import wlex_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [7:0]  data;
        logic [31:0] num;
        logic        fin;
    } token_t;

    typedef struct {
        logic [7:0] c;
        bit         typed;
        kind_t      k;
        logic [7:0] d;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic [7:0]         ch;
    logic               ch_valid;
    logic               ch_stall;
    logic [2:0]         kind;
    logic [7:0]         out_byte;
    logic signed [31:0] number;
    logic               last;
    logic               res_valid;
    logic               res_stall;

    token_t     lexed_q[$];
    token_t     step_res[$];
    token_t     want;
    logic [7:0] line_q[$];
    dir_row_t   dir_tab[24];
    int         errs = 0;
    int         rand_sent = 0;
    bit         calm = 1'b0;

    lex_phase_t  ph;
    quote_t      qs;
    logic [2:0]  held;
    logic        close_seen;
    sign_t       sg;
    num_phase_t  np;
    logic [31:0] acc;

    word_lexer_with_escapes_and_numbers_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (ch),
        .ch_valid  (ch_valid),
        .ch_stall  (ch_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .number    (number),
        .last      (last),
        .res_valid (res_valid),
        .res_stall (res_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_dig(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void put(input kind_t k, input logic [7:0] d, input logic [31:0] n);
        token_t t;
        t.kind = k;
        t.data = d;
        t.num  = n;
        t.fin  = 1'b0;
        step_res.push_back(t);
    endfunction

    function automatic void classify(input logic [7:0] b);
        case (np)
            NP_START:
            begin
                if (b == CH_PLUS && sg == SG_NONE)
                    sg = SG_PLUS;
                else if (b == CH_MINUS && sg == SG_NONE)
                    sg = SG_MINUS;
                else if (b == CH_ZERO)
                begin
                    np  = NP_ZERO;
                    acc = 32'd0;
                end
                else if (is_dig(b))
                begin
                    np  = NP_DEC;
                    acc = b - CH_ZERO;
                end
                else
                    np = NP_NOT;
            end
            NP_ZERO:
            begin
                if (b == CH_LX)
                begin
                    np  = NP_HEX;
                    acc = 32'd0;
                end
                else if (is_dig(b))
                begin
                    np  = NP_OCT;
                    acc = acc * 8 + (b - CH_ZERO);
                end
                else
                    np = NP_NOT;
            end
            NP_HEX:
            begin
                if (b >= CH_UA && b <= CH_UZ)
                    acc = (acc << 4) + (b - CH_UA) + 32'd10;
                else if (b >= CH_LA && b <= CH_LZ)
                    acc = (acc << 4) + (b - CH_LA) + 32'd10;
                else if (is_dig(b))
                    acc = (acc << 4) + (b - CH_ZERO);
                else
                    np = NP_NOT;
            end
            NP_OCT:
            begin
                if (is_dig(b))
                    acc = acc * 8 + (b - CH_ZERO);
                else
                    np = NP_NOT;
            end
            NP_DEC:
            begin
                if (is_dig(b))
                    acc = acc * 10 + (b - CH_ZERO);
                else
                    np = NP_NOT;
            end
            default:
                np = NP_NOT;
        endcase
    endfunction

    function automatic void word_byte(input logic [7:0] b, input logic rc);
        put(KIND_BYTE, b, 32'd0);
        classify(b);
        close_seen = rc;
    endfunction

    function automatic void clear_word();
        qs         = Q_PLAIN;
        held       = 3'd0;
        close_seen = 1'b0;
        sg         = SG_NONE;
        np         = NP_START;
        acc        = 32'd0;
    endfunction

    function automatic bit end_word();
        bit err;
        err = qs == Q_OPEN || (qs == Q_CLOSED && !close_seen);
        if (err)
            put(KIND_ERROR, 8'd0, 32'd0);
        else if (np == NP_ZERO || np == NP_HEX || np == NP_OCT || np == NP_DEC)
            put(KIND_NUMBER, 8'd0, (sg == SG_MINUS) ? -acc : acc);
        else
            put(KIND_WORD, 8'd0, 32'd0);
        clear_word();
        return err;
    endfunction

    function automatic void raw_in_word(input logic [7:0] c);
        if (c == CH_NUL)
        begin
            void'(end_word());
            put(KIND_LINE, 8'd0, 32'd0);
            ph = LX_BETWEEN;
        end
        else if (is_blank(c) && qs != Q_OPEN)
            ph = end_word() ? LX_DISCARD : LX_BETWEEN;
        else if (c == CH_CLOSE)
        begin
            qs = Q_CLOSED;
            word_byte(c, 1'b1);
        end
        else if (c == CH_BSLASH)
        begin
            close_seen = 1'b0;
            ph = LX_ESC;
        end
        else
            word_byte(c, 1'b0);
    endfunction

    function automatic void lex_char(input logic [7:0] c);
        step_res.delete();
        case (ph)
            LX_BETWEEN:
            begin
                if (c == CH_NUL)
                    put(KIND_LINE, 8'd0, 32'd0);
                else if (!is_blank(c))
                begin
                    clear_word();
                    qs = (c == CH_OPEN) ? Q_OPEN : Q_PLAIN;
                    ph = LX_WORD;
                    raw_in_word(c);
                end
            end
            LX_WORD:
                raw_in_word(c);
            LX_ESC:
            begin
                ph = LX_WORD;
                if (c == CH_LN)
                    word_byte(CH_NL, 1'b0);
                else if (c == CH_LB)
                    word_byte(CH_BKSP, 1'b0);
                else if (c == CH_LT)
                    word_byte(CH_TAB, 1'b0);
                else if (c == CH_ZERO)
                begin
                    close_seen = 1'b0;
                    ph = LX_ESC_ZERO;
                end
                else if (c == CH_NUL)
                begin
                    word_byte(CH_BSLASH, 1'b0);
                    raw_in_word(CH_NUL);
                end
                else
                    word_byte(c, c == CH_CLOSE);
            end
            LX_ESC_ZERO:
            begin
                if (c >= CH_ZERO && c <= CH_SEVEN)
                begin
                    held = c[2:0];
                    ph = LX_ESC_DIGIT;
                end
                else
                begin
                    ph = LX_WORD;
                    word_byte(CH_ZERO, 1'b0);
                    raw_in_word(c);
                end
            end
            LX_ESC_DIGIT:
            begin
                ph = LX_WORD;
                if (c >= CH_ZERO && c <= CH_SEVEN)
                    word_byte({2'b00, held, c[2:0]}, 1'b0);
                else
                begin
                    word_byte(CH_ZERO, 1'b0);
                    word_byte(CH_ZERO + {5'd0, held}, 1'b0);
                    raw_in_word(c);
                end
                held = 3'd0;
            end
            default:
            begin
                if (c == CH_NUL)
                begin
                    put(KIND_LINE, 8'd0, 32'd0);
                    ph = LX_BETWEEN;
                    clear_word();
                end
            end
        endcase
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].fin = 1'b1;
    endfunction

    function automatic void add_chars(input string s, input int unsigned n);
        repeat (n)
            line_q.push_back(s[$urandom_range(0, s.len() - 1)]);
    endfunction

    function automatic logic [7:0] blank_char();
        logic [7:0] v;
        v = 8'($urandom_range(8, 13));
        return (v == 8'd8) ? CH_SPACE : v;
    endfunction

    function automatic void add_sign();
        if ($urandom_range(0, 2) == 0)
            add_chars("+-", 1);
    endfunction

    function automatic void add_escape();
        line_q.push_back(CH_BSLASH);
        case ($urandom_range(0, 5))
            0: add_chars("nbt", 1);
            1:
            begin
                line_q.push_back(CH_ZERO);
                add_chars("01234567", 2);
            end
            2:
            begin
                line_q.push_back(CH_ZERO);
                add_chars("01234567 9a)", 1);
                add_chars("0123456789 )x", 1);
            end
            3: line_q.push_back(CH_CLOSE);
            4: line_q.push_back(8'($urandom_range(1, 255)));
            default: add_chars("nbt0)\\", 1);
        endcase
    endfunction

    function automatic void add_paren();
        line_q.push_back(CH_OPEN);
        add_chars("ab1-+x \t", $urandom_range(0, 5));
        if ($urandom_range(0, 3) == 0)
            add_escape();
        case ($urandom_range(0, 9))
            7:
            begin
                line_q.push_back(CH_CLOSE);
                add_chars("ab1", 1);
            end
            8: ;
            default: line_q.push_back(CH_CLOSE);
        endcase
    endfunction

    function automatic void add_word();
        case ($urandom_range(0, 9))
            0:
            begin
                add_sign();
                add_chars("123456789", 1);
                add_chars("0123456789", $urandom_range(0, 11));
            end
            1:
            begin
                add_sign();
                line_q.push_back(CH_ZERO);
                add_chars("0123456789", $urandom_range(0, 12));
            end
            2:
            begin
                add_sign();
                line_q.push_back(CH_ZERO);
                line_q.push_back(CH_LX);
                add_chars("0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ",
                          $urandom_range(0, 10));
            end
            3:
                repeat ($urandom_range(1, 6))
                    line_q.push_back(8'($urandom_range(33, 126)));
            4:
                repeat ($urandom_range(1, 4))
                    line_q.push_back(8'($urandom_range(128, 255)));
            5:
                repeat ($urandom_range(1, 3))
                begin
                    add_chars("ab", $urandom_range(0, 1));
                    add_escape();
                end
            6:
                add_paren();
            7:
                add_chars("+-0x19aZ)\\", $urandom_range(1, 5));
            8:
                repeat ($urandom_range(1, 4))
                    line_q.push_back(8'($urandom_range(0, 255)));
            default:
            begin
                add_sign();
                add_chars("0123456789", $urandom_range(1, 3));
                add_escape();
                add_chars("0123456789", $urandom_range(0, 2));
            end
        endcase
    endfunction

    function automatic void build_line();
        int unsigned n;
        int unsigned t;
        line_q.delete();
        if ($urandom_range(0, 3) == 0)
            line_q.push_back(blank_char());
        n = $urandom_range(1, 6);
        for (t = 0; t < n; t++)
        begin
            add_word();
            if (t + 1 < n || $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2))
                    line_q.push_back(blank_char());
        end
        if ($urandom_range(0, 9) == 0)
            line_q.push_back(CH_BSLASH);
        line_q.push_back(CH_NUL);
    endfunction

    task automatic send_char(input logic [7:0] c);
        if (!calm && $urandom_range(0, 99) < 27)
        begin
            ch_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < 20)
                @(posedge clk);
        end
        ch       <= c;
        ch_valid <= 1'b1;
        @(posedge clk);
        while (ch_stall)
            @(posedge clk);
        lex_char(c);
    endtask

    task automatic queue_step();
        foreach (step_res[i])
            lexed_q.push_back(step_res[i]);
    endtask

    task automatic drain();
        ch_valid <= 1'b0;
        do
            @(posedge clk);
        while (lexed_q.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (lexed_q.size() == 0)
            begin
                errs++;
                $display("%0t: unexpected result: kind %0d byte %02h number %0d last %0b",
                         $time, kind, out_byte, number, last);
            end
            else
            begin
                want = lexed_q.pop_front();
                if (kind !== want.kind || out_byte !== want.data ||
                    number !== want.num || last !== want.fin)
                begin
                    errs++;
                    $display("%0t: mismatch: expected kind %0d byte %02h number %0d last %0b",
                             $time, want.kind, want.data, $signed(want.num), want.fin);
                    $display("%0t:           actual   kind %0d byte %02h number %0d last %0b",
                             $time, kind, out_byte, number, last);
                end
            end
        end
        res_stall <= !calm && ($urandom_range(0, 99) < 27);
    end

    initial
    begin
        token_t typed_res;

        rst_n     <= 1'b0;
        ch        <= CH_NUL;
        ch_valid  <= 1'b0;
        res_stall <= 1'b0;
        ph = LX_BETWEEN;
        clear_word();

        dir_tab = '{
            '{CH_NUL,    1'b1, KIND_LINE,  8'h00},
            '{CH_LA,     1'b1, KIND_BYTE,  CH_LA},
            '{8'hFF,     1'b1, KIND_BYTE,  8'hFF},
            '{CH_SPACE,  1'b1, KIND_WORD,  8'h00},
            '{CH_MINUS,  1'b0, KIND_BYTE,  8'h00},
            '{CH_ZERO,   1'b0, KIND_BYTE,  8'h00},
            '{CH_LX,     1'b0, KIND_BYTE,  8'h00},
            '{CH_LZ,     1'b0, KIND_BYTE,  8'h00},
            '{CH_TAB,    1'b0, KIND_BYTE,  8'h00},
            '{CH_OPEN,   1'b0, KIND_BYTE,  8'h00},
            '{CH_SPACE,  1'b0, KIND_BYTE,  8'h00},
            '{CH_CLOSE,  1'b0, KIND_BYTE,  8'h00},
            '{8'h71,     1'b0, KIND_BYTE,  8'h00},
            '{CH_SPACE,  1'b1, KIND_ERROR, 8'h00},
            '{8'h6B,     1'b0, KIND_BYTE,  8'h00},
            '{CH_NUL,    1'b1, KIND_LINE,  8'h00},
            '{CH_BSLASH, 1'b0, KIND_BYTE,  8'h00},
            '{CH_ZERO,   1'b0, KIND_BYTE,  8'h00},
            '{CH_SEVEN,  1'b0, KIND_BYTE,  8'h00},
            '{CH_SEVEN,  1'b0, KIND_BYTE,  8'h00},
            '{CH_BSLASH, 1'b0, KIND_BYTE,  8'h00},
            '{CH_NUL,    1'b0, KIND_BYTE,  8'h00},
            '{CH_OPEN,   1'b0, KIND_BYTE,  8'h00},
            '{CH_NUL,    1'b0, KIND_BYTE,  8'h00}
        };

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            send_char(dir_tab[i].c);
            if (dir_tab[i].typed)
            begin
                typed_res.kind = dir_tab[i].k;
                typed_res.data = dir_tab[i].d;
                typed_res.num  = 32'd0;
                typed_res.fin  = 1'b1;
                lexed_q.push_back(typed_res);
            end
            else
                queue_step();
        end

        // Let every result of the directed table arrive before random lines start.
        drain();

        while (rand_sent < 500)
        begin
            build_line();
            foreach (line_q[i])
            begin
                calm = rand_sent >= 150 && rand_sent < 270;
                if (rand_sent == 320)
                    drain();
                send_char(line_q[i]);
                queue_step();
                rand_sent++;
            end
        end

        ch_valid <= 1'b0;
        while (lexed_q.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        if (errs == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/wlex_pkg.sv
design/wlex_step.sv
design/word_lexer_with_escapes_and_numbers_core.sv
design/wlex_checker.sv
verif/tb_word_lexer_with_escapes_and_numbers_core.sv
